### rtl/vrra_pkg.sv
// Package with types, constants and command codes of the record ring allocator.
package vrra_pkg;

	localparam int unsigned BUF_WORDS = 4096;
	localparam int unsigned AW        = $clog2(BUF_WORDS);

	localparam logic [31:0] MARK_WRAP = 32'hFFFF_FFFF;
	localparam logic [31:0] MARK_END  = 32'hFFFF_FFFE;
	localparam logic [12:0] RESERVE_RST = 13'd1024;
	localparam logic [12:0] RESERVE_MIN = 13'd2;
	localparam logic signed [16:0] FREE_CAP = 17'sd16383;

	typedef enum logic [2:0] {
		CMD_WRITE   = 3'd0,
		CMD_FLUSH   = 3'd1,
		CMD_RELEASE = 3'd2,
		CMD_RESCAN  = 3'd3,
		CMD_READ    = 3'd4,
		CMD_FINISH  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_LAST  = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_RANGE    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		MW_NONE,
		MW_DATA,
		MW_FL_ZERO,
		MW_FL_LEN,
		MW_FL_HDR,
		MW_WRAP_LEN,
		MW_WRAP_HDR,
		MW_RELEASE,
		MW_END_LEN,
		MW_END_HDR
	} mem_wr_t;

	typedef enum logic [2:0] {
		RD_NONE,
		RD_FLAG,
		RD_LEN,
		RD_LASTLEN,
		RD_WORD
	} mem_rd_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_FL1,
		S_FL2,
		S_ADV,
		S_WRAP2,
		S_SCAN_CHK,
		S_SCAN_FLAG,
		S_SCAN_LEN,
		S_RD_CHK,
		S_RD_CAP,
		S_FIN2,
		S_LL,
		S_PUT
	} state_t;

	typedef struct packed {
		logic    latch;
		logic    st_set;
		status_t st_code;
		logic    word_cap;
		mem_wr_t wr;
		mem_rd_t rd;
		logic    commit;
		logic    adv_step;
		logic    wrap_reset;
		logic    space_set;
		logic    scan_stop;
		logic    scan_step;
		logic    put;
	} dp_ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic space;
		logic wr_ok;
		logic fl_ok;
		logic adv_fits;
		logic adv_free_pos;
		logic scan_done;
		logic rd_nz;
		logic last_valid;
		logic in_range;
		logic out_busy;
	} dp_stat_t;

endpackage

### rtl/vrra_ifs.sv
// Request and result channel interfaces of the record ring allocator.
interface vrra_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] data_word;
	logic [11:0] word_offset;
	logic [11:0] record_length;
	logic [11:0] header_address;

	modport source (output valid, cmd, data_word, word_offset, record_length,
		header_address, input ready);
	modport sink (input valid, cmd, data_word, word_offset, record_length,
		header_address, output ready);
endinterface

interface vrra_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_word;
	logic [11:0] last_length;
	logic [1:0]  status;
	logic        space_ready;
	logic [11:0] data_base;

	modport source (output valid, read_word, last_length, status, space_ready,
		data_base, input ready);
	modport sink (input valid, read_word, last_length, status, space_ready,
		data_base, output ready);
endinterface

### rtl/vrra_ctrl.sv
// Sequencer that steps each request through its memory accesses.
module vrra_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vrra_pkg::dp_stat_t stat,
	output vrra_pkg::dp_ctrl_t ctrl
);

	vrra_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrra_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctrl     = '0;
		ctrl.st_code = vrra_pkg::ST_OK;
		ctrl.wr      = vrra_pkg::MW_NONE;
		ctrl.rd      = vrra_pkg::RD_NONE;
		unique case (state_q)
			vrra_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.latch = 1'b1;
					state_d    = vrra_pkg::S_DISPATCH;
				end
			end
			vrra_pkg::S_DISPATCH: begin
				state_d = vrra_pkg::S_LL;
				case (stat.cmd)
					vrra_pkg::CMD_WRITE: begin
						if (!stat.space) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = vrra_pkg::ST_NO_SPACE;
						end else if (!stat.wr_ok) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = vrra_pkg::ST_RANGE;
						end else begin
							ctrl.wr = vrra_pkg::MW_DATA;
						end
					end
					vrra_pkg::CMD_FLUSH: begin
						if (!stat.space) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = vrra_pkg::ST_NO_SPACE;
						end else if (!stat.fl_ok) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = vrra_pkg::ST_RANGE;
						end else begin
							ctrl.wr = vrra_pkg::MW_FL_ZERO;
							state_d = vrra_pkg::S_FL1;
						end
					end
					vrra_pkg::CMD_RELEASE: ctrl.wr = vrra_pkg::MW_RELEASE;
					vrra_pkg::CMD_RESCAN:  state_d = vrra_pkg::S_SCAN_CHK;
					vrra_pkg::CMD_READ: begin
						if (!stat.last_valid) begin
							ctrl.st_set  = 1'b1;
							ctrl.st_code = vrra_pkg::ST_NO_LAST;
						end else begin
							ctrl.rd = vrra_pkg::RD_LASTLEN;
							state_d = vrra_pkg::S_RD_CHK;
						end
					end
					vrra_pkg::CMD_FINISH: begin
						ctrl.wr = vrra_pkg::MW_END_LEN;
						state_d = vrra_pkg::S_FIN2;
					end
					default: state_d = vrra_pkg::S_LL;
				endcase
			end
			vrra_pkg::S_FL1: begin
				ctrl.wr = vrra_pkg::MW_FL_LEN;
				state_d = vrra_pkg::S_FL2;
			end
			vrra_pkg::S_FL2: begin
				ctrl.wr     = vrra_pkg::MW_FL_HDR;
				ctrl.commit = 1'b1;
				state_d     = vrra_pkg::S_ADV;
			end
			vrra_pkg::S_ADV: begin
				if (stat.adv_fits) begin
					ctrl.adv_step = 1'b1;
					if (stat.adv_free_pos) begin
						state_d = vrra_pkg::S_SCAN_CHK;
					end else begin
						ctrl.space_set = 1'b1;
						state_d        = vrra_pkg::S_LL;
					end
				end else begin
					ctrl.wr = vrra_pkg::MW_WRAP_LEN;
					state_d = vrra_pkg::S_WRAP2;
				end
			end
			vrra_pkg::S_WRAP2: begin
				ctrl.wr         = vrra_pkg::MW_WRAP_HDR;
				ctrl.wrap_reset = 1'b1;
				state_d         = vrra_pkg::S_SCAN_CHK;
			end
			vrra_pkg::S_SCAN_CHK: begin
				if (stat.scan_done) begin
					ctrl.space_set = 1'b1;
					state_d        = vrra_pkg::S_LL;
				end else begin
					ctrl.rd = vrra_pkg::RD_FLAG;
					state_d = vrra_pkg::S_SCAN_FLAG;
				end
			end
			vrra_pkg::S_SCAN_FLAG: begin
				if (stat.rd_nz) begin
					ctrl.scan_stop = 1'b1;
					state_d        = vrra_pkg::S_LL;
				end else begin
					ctrl.rd = vrra_pkg::RD_LEN;
					state_d = vrra_pkg::S_SCAN_LEN;
				end
			end
			vrra_pkg::S_SCAN_LEN: begin
				ctrl.scan_step = 1'b1;
				state_d        = vrra_pkg::S_SCAN_CHK;
			end
			vrra_pkg::S_RD_CHK: begin
				if (!stat.in_range) begin
					ctrl.st_set  = 1'b1;
					ctrl.st_code = vrra_pkg::ST_RANGE;
					state_d      = vrra_pkg::S_LL;
				end else begin
					ctrl.rd = vrra_pkg::RD_WORD;
					state_d = vrra_pkg::S_RD_CAP;
				end
			end
			vrra_pkg::S_RD_CAP: begin
				ctrl.word_cap = 1'b1;
				state_d       = vrra_pkg::S_LL;
			end
			vrra_pkg::S_FIN2: begin
				ctrl.wr = vrra_pkg::MW_END_HDR;
				state_d = vrra_pkg::S_LL;
			end
			vrra_pkg::S_LL: begin
				ctrl.rd = vrra_pkg::RD_LASTLEN;
				state_d = vrra_pkg::S_PUT;
			end
			vrra_pkg::S_PUT: begin
				if (!stat.out_busy) begin
					ctrl.put = 1'b1;
					state_d  = vrra_pkg::S_IDLE;
				end
			end
			default: state_d = vrra_pkg::S_IDLE;
		endcase
	end

endmodule

### rtl/vrra_dp.sv
// Datapath: ring memory, pointers, free count and the result register.
module vrra_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  vrra_pkg::dp_ctrl_t ctrl,
	output vrra_pkg::dp_stat_t stat,
	input  logic               cfg_we,
	input  logic [12:0]        cfg_wdata,
	input  logic [2:0]         cmd,
	input  logic [31:0]        data_word,
	input  logic [11:0]        word_offset,
	input  logic [11:0]        record_length,
	input  logic [11:0]        header_address,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [31:0]        read_word,
	output logic [11:0]        last_length,
	output logic [1:0]         status,
	output logic               space_ready,
	output logic [11:0]        data_base
);

	localparam int unsigned AW = vrra_pkg::AW;

	logic [31:0] mem_q [vrra_pkg::BUF_WORDS];
	logic [31:0] mem_rd_q;
	logic        rd_zero_q;
	logic        w0_ok_q;

	logic [12:0]        reserve_q;
	logic [2:0]         cmd_q;
	logic [31:0]        data_q;
	logic [11:0]        off_q, len_q, hdr_q;
	logic [AW-1:0]      wptr_q, fscan_q, ldp_q;
	logic signed [14:0] free_q;
	logic               space_q, last_valid_q;
	logic [13:0]        next_q;
	logic [1:0]         st_q;
	logic [31:0]        word_q;

	logic               out_valid_q, out_space_q;
	logic [31:0]        out_word_q;
	logic [11:0]        out_len_q, out_base_q;
	logic [1:0]         out_st_q;

	logic [12:0]        r_eff;
	logic [31:0]        rdata;
	logic               we;
	logic [AW-1:0]      waddr, raddr;
	logic [31:0]        wdata;
	logic signed [14:0] adv_free;
	logic signed [16:0] scan_sum;
	logic [11:0]        ll_now;

	assign r_eff = (reserve_q < vrra_pkg::RESERVE_MIN) ? vrra_pkg::RESERVE_MIN : reserve_q;
	assign rdata = rd_zero_q ? 32'd0 : mem_rd_q;

	always_comb begin
		we    = 1'b1;
		waddr = wptr_q;
		wdata = 32'd1;
		case (ctrl.wr)
			vrra_pkg::MW_DATA: begin
				waddr = AW'(wptr_q + AW'(2) + AW'(off_q));
				wdata = data_q;
			end
			vrra_pkg::MW_FL_ZERO: begin
				waddr = AW'(wptr_q + AW'(2) + AW'(len_q));
				wdata = 32'd0;
			end
			vrra_pkg::MW_FL_LEN: begin
				waddr = AW'(wptr_q + AW'(1));
				wdata = {20'd0, len_q};
			end
			vrra_pkg::MW_FL_HDR: waddr = wptr_q;
			vrra_pkg::MW_WRAP_LEN: begin
				waddr = AW'(next_q + 14'd1);
				wdata = vrra_pkg::MARK_WRAP;
			end
			vrra_pkg::MW_WRAP_HDR: waddr = AW'(next_q);
			vrra_pkg::MW_RELEASE: begin
				waddr = AW'(hdr_q);
				wdata = 32'd0;
			end
			vrra_pkg::MW_END_LEN: begin
				waddr = AW'(wptr_q + AW'(1));
				wdata = vrra_pkg::MARK_END;
			end
			vrra_pkg::MW_END_HDR: waddr = wptr_q;
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		case (ctrl.rd)
			vrra_pkg::RD_LEN:     raddr = AW'(fscan_q + AW'(1));
			vrra_pkg::RD_LASTLEN: raddr = AW'(ldp_q - AW'(1));
			vrra_pkg::RD_WORD:    raddr = AW'(ldp_q + AW'(off_q));
			default:              raddr = fscan_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (ctrl.rd != vrra_pkg::RD_NONE) begin
			mem_rd_q  <= mem_q[raddr];
			rd_zero_q <= (raddr == '0) && !w0_ok_q;
		end
	end

	// Only word zero has a defined value before it is first written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_ok_q <= 1'b0;
		end else if (we && waddr == '0) begin
			w0_ok_q <= 1'b1;
		end
	end

	assign adv_free = $signed({3'd0, fscan_q}) - $signed({1'b0, next_q});
	assign scan_sum = 17'(free_q) + $signed({3'd0, rdata[13:0]}) + 17'sd2;

	always_comb begin
		if (!last_valid_q || rdata[31]) begin
			ll_now = 12'd0;
		end else begin
			ll_now = rdata[11:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q  <= cmd;
			data_q <= data_word;
			off_q  <= word_offset;
			len_q  <= record_length;
			hdr_q  <= header_address;
		end
		if (ctrl.commit) begin
			next_q <= 14'(wptr_q) + 14'(len_q) + 14'd2;
		end
		if (ctrl.latch) begin
			word_q <= 32'd0;
		end else if (ctrl.word_cap) begin
			word_q <= rdata;
		end
		if (ctrl.latch) begin
			st_q <= vrra_pkg::ST_OK;
		end else if (ctrl.st_set) begin
			st_q <= ctrl.st_code;
		end
		if (ctrl.put) begin
			out_word_q  <= word_q;
			out_len_q   <= ll_now;
			out_st_q    <= st_q;
			out_space_q <= space_q;
			out_base_q  <= 12'(wptr_q + AW'(2));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserve_q    <= vrra_pkg::RESERVE_RST;
			wptr_q       <= '0;
			fscan_q      <= '0;
			free_q       <= '0;
			space_q      <= 1'b1;
			ldp_q        <= '0;
			last_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				reserve_q <= cfg_wdata;
			end
			if (ctrl.commit) begin
				ldp_q        <= AW'(wptr_q + AW'(2));
				last_valid_q <= 1'b1;
			end
			if (ctrl.adv_step) begin
				wptr_q <= AW'(next_q);
				free_q <= adv_free;
			end
			if (ctrl.wrap_reset) begin
				wptr_q  <= '0;
				fscan_q <= '0;
				free_q  <= '0;
			end
			if (ctrl.space_set) begin
				space_q <= 1'b1;
			end
			if (ctrl.scan_stop) begin
				space_q <= 1'b0;
			end
			if (ctrl.scan_step) begin
				// A length word with its top bit set (wrap or end marker) sends the scan back to word zero.
				if (rdata[31]) begin
					free_q  <= $signed({2'd0, r_eff});
					fscan_q <= '0;
				end else begin
					if (rdata[30:14] != '0 || scan_sum > vrra_pkg::FREE_CAP) begin
						free_q <= 15'(vrra_pkg::FREE_CAP);
					end else begin
						free_q <= scan_sum[14:0];
					end
					fscan_q <= AW'(fscan_q + AW'(rdata[11:0]) + AW'(2));
				end
			end
			if (ctrl.put) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.cmd          = vrra_pkg::cmd_t'(cmd_q);
		stat.space        = space_q;
		stat.wr_ok        = ({1'b0, off_q} + 13'd3) <= r_eff;
		stat.fl_ok        = ({1'b0, len_q} + 13'd3) <= r_eff;
		stat.adv_fits     = (next_q + {1'b0, r_eff}) <= 14'(vrra_pkg::BUF_WORDS);
		stat.adv_free_pos = adv_free > 15'sd0;
		stat.scan_done    = free_q >= $signed({2'd0, r_eff});
		stat.rd_nz        = rdata != 32'd0;
		stat.last_valid   = last_valid_q;
		stat.in_range     = !rdata[31] && ((rdata[30:12] != '0) || (off_q < rdata[11:0]));
		stat.out_busy     = out_valid_q && !out_ready;
	end

	assign out_valid   = out_valid_q;
	assign read_word   = out_word_q;
	assign last_length = out_len_q;
	assign status      = out_st_q;
	assign space_ready = out_space_q;
	assign data_base   = out_base_q;

endmodule

### rtl/variable_record_ring_allocator.sv
// Top level of the variable-length record ring allocator.
//
//   port     dir  handshake        contents
//   in_ch    in   valid / ready    cmd, data_word, word_offset, record_length, header_address
//   out_ch   out  valid / ready    read_word, last_length, status, space_ready, data_base
//   cfg      in   cfg_we           cfg_wdata = reserve_words
//
// One request at a time, from the accepting cycle until ready returns. Every request ends
// by reading the last length and putting its result; a read first checks the range and
// captures the word, finish writes the end marker, and a flush writes its record, then
// advances with a wrap or a scan where needed. A walk steps per header (flag read, length read, update).
// Reset clears pointers and control; there is no clearing pass. A result waits in the
// output register while the next request is taken; the one after it stalls until then.
module variable_record_ring_allocator (
	input  logic        clk,
	input  logic        arst_n,
	vrra_in_if.sink     in_ch,
	vrra_out_if.source  out_ch,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata
);

	vrra_pkg::dp_ctrl_t ctrl;
	vrra_pkg::dp_stat_t stat;

	vrra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	vrra_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd            (in_ch.cmd),
		.data_word      (in_ch.data_word),
		.word_offset    (in_ch.word_offset),
		.record_length  (in_ch.record_length),
		.header_address (in_ch.header_address),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.read_word      (out_ch.read_word),
		.last_length    (out_ch.last_length),
		.status         (out_ch.status),
		.space_ready    (out_ch.space_ready),
		.data_base      (out_ch.data_base)
	);

endmodule

### sim/ring_checker.sv
// Checker that predicts every result of the record ring allocator and compares it.
`timescale 1ns / 100ps
module ring_checker (
	input  logic        clk,
	input  logic        arst_n,
	vrra_in_if          req,
	vrra_out_if         res,
	input  logic        cfg_we,
	input  logic [12:0] cfg_wdata,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic [31:0] read_word;
		logic [11:0] last_length;
		logic [1:0]  status;
		logic        space_ready;
		logic [11:0] data_base;
	} ring_result_t;

	bit [31:0]   ring [vrra_pkg::BUF_WORDS];
	bit          known [vrra_pkg::BUF_WORDS];
	logic [11:0] hdr_ptr;
	logic [11:0] scan_ptr;
	longint      free_cnt;
	bit          space;
	logic [11:0] last_ptr;
	bit          have_last;
	logic [12:0] reserve;

	ring_result_t results_due[$];
	logic [11:0]  committed_hdrs[$];

	// A trial run logs every memory write so that it can be undone afterwards.
	bit          trial;
	bit          undef_hit;
	int          undo_addr[$];
	bit [31:0]   undo_val[$];
	bit          undo_known[$];

	function automatic longint eff_reserve();
		return (reserve < vrra_pkg::RESERVE_MIN) ? longint'(vrra_pkg::RESERVE_MIN) :
			longint'(reserve);
	endfunction

	function automatic bit [31:0] mem_rd(longint a);
		int i;
		i = int'(a % vrra_pkg::BUF_WORDS);
		if (!known[i])
			undef_hit = 1;
		return ring[i];
	endfunction

	function automatic void mem_wr(longint a, bit [31:0] v);
		int i;
		i = int'(a % vrra_pkg::BUF_WORDS);
		if (trial) begin
			undo_addr.push_back(i);
			undo_val.push_back(ring[i]);
			undo_known.push_back(known[i]);
		end
		ring[i] = v;
		known[i] = 1;
	endfunction

	function automatic void scan_free();
		longint r;
		longint d;
		bit [31:0] lw;
		r = eff_reserve();
		d = free_cnt;
		while (d < r) begin
			if (mem_rd(scan_ptr) != 0) begin
				space = 0;
				free_cnt = d;
				return;
			end
			lw = mem_rd(longint'(scan_ptr) + 1);
			if (undef_hit)
				return;
			if (lw[31]) begin
				d = r;
				scan_ptr = '0;
			end else begin
				d = d + longint'(lw) + 2;
				if (d > vrra_pkg::FREE_CAP)
					d = vrra_pkg::FREE_CAP;
				scan_ptr = 12'(longint'(scan_ptr) + longint'(lw) + 2);
			end
		end
		space = 1;
		free_cnt = d;
	endfunction

	function automatic void advance(logic [11:0] len);
		longint nxt;
		nxt = longint'(hdr_ptr) + longint'(len) + 2;
		if (longint'(vrra_pkg::BUF_WORDS) - nxt >= eff_reserve()) begin
			hdr_ptr = 12'(nxt);
			free_cnt = longint'(scan_ptr) - nxt;
			if (free_cnt > 0)
				scan_free();
			else
				space = 1;
		end else begin
			mem_wr(nxt + 1, vrra_pkg::MARK_WRAP);
			mem_wr(nxt, 32'd1);
			hdr_ptr = '0;
			scan_ptr = '0;
			free_cnt = 0;
			scan_free();
		end
	endfunction

	function automatic bit [31:0] last_len();
		bit [31:0] lw;
		if (!have_last)
			return 0;
		lw = mem_rd(longint'(last_ptr) + vrra_pkg::BUF_WORDS - 1);
		return lw[31] ? 32'd0 : lw;
	endfunction

	function automatic ring_result_t apply_request(logic [2:0] c, logic [31:0] d,
			logic [11:0] o, logic [11:0] l, logic [11:0] h);
		ring_result_t rr;
		bit [31:0] word;
		vrra_pkg::status_t st;
		longint r;
		word = 0;
		st = vrra_pkg::ST_OK;
		r = eff_reserve();
		case (c)
			vrra_pkg::CMD_WRITE: begin
				if (!space)
					st = vrra_pkg::ST_NO_SPACE;
				else if (longint'(o) + 3 > r)
					st = vrra_pkg::ST_RANGE;
				else
					mem_wr(longint'(hdr_ptr) + 2 + o, d);
			end
			vrra_pkg::CMD_FLUSH: begin
				if (!space) begin
					st = vrra_pkg::ST_NO_SPACE;
				end else if (longint'(l) + 3 > r) begin
					st = vrra_pkg::ST_RANGE;
				end else begin
					mem_wr(longint'(hdr_ptr) + 2 + l, 32'd0);
					mem_wr(longint'(hdr_ptr) + 1, {20'd0, l});
					mem_wr(hdr_ptr, 32'd1);
					if (!trial)
						committed_hdrs.push_back(hdr_ptr);
					last_ptr = hdr_ptr + 12'd2;
					have_last = 1;
					advance(l);
				end
			end
			vrra_pkg::CMD_RELEASE: mem_wr(h, 32'd0);
			vrra_pkg::CMD_RESCAN: scan_free();
			vrra_pkg::CMD_READ: begin
				if (!have_last)
					st = vrra_pkg::ST_NO_LAST;
				else if (32'(o) >= last_len())
					st = vrra_pkg::ST_RANGE;
				else
					word = mem_rd(longint'(last_ptr) + o);
			end
			vrra_pkg::CMD_FINISH: begin
				mem_wr(longint'(hdr_ptr) + 1, vrra_pkg::MARK_END);
				mem_wr(hdr_ptr, 32'd1);
			end
			default: ;
		endcase
		rr.read_word = word;
		rr.last_length = 12'(last_len());
		rr.status = st;
		rr.space_ready = space;
		rr.data_base = hdr_ptr + 12'd2;
		return rr;
	endfunction

	// Tells whether a request would make the block read a ring word never written.
	task automatic try_request(input logic [2:0] c, input logic [31:0] d,
			input logic [11:0] o, input logic [11:0] l, input logic [11:0] h,
			output bit ok);
		logic [11:0] s_hdr, s_scan, s_last;
		longint s_free;
		bit s_space, s_have;
		ring_result_t dummy;
		s_hdr = hdr_ptr;
		s_scan = scan_ptr;
		s_last = last_ptr;
		s_free = free_cnt;
		s_space = space;
		s_have = have_last;
		trial = 1;
		undef_hit = 0;
		dummy = apply_request(c, d, o, l, h);
		ok = !undef_hit;
		while (undo_addr.size() > 0) begin
			ring[undo_addr[$]] = undo_val[$];
			known[undo_addr[$]] = undo_known[$];
			undo_addr.pop_back();
			undo_val.pop_back();
			undo_known.pop_back();
		end
		hdr_ptr = s_hdr;
		scan_ptr = s_scan;
		last_ptr = s_last;
		free_cnt = s_free;
		space = s_space;
		have_last = s_have;
		trial = 0;
		undef_hit = 0;
	endtask

	function automatic logic [11:0] oldest_record();
		if (committed_hdrs.size() == 0)
			return 12'($urandom);
		return committed_hdrs.pop_front();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ring_result_t got;
		ring_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < vrra_pkg::BUF_WORDS; i++) begin
				ring[i] = 0;
				known[i] = 0;
			end
			known[0] = 1;
			hdr_ptr = '0;
			scan_ptr = '0;
			free_cnt = 0;
			space = 1;
			last_ptr = '0;
			have_last = 0;
			reserve = vrra_pkg::RESERVE_RST;
			results_due.delete();
			committed_hdrs.delete();
			outstanding = 0;
		end else begin
			if (res.valid && res.ready) begin
				got = '{res.read_word, res.last_length, res.status, res.space_ready,
					res.data_base};
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result with no request pending: %p", got);
				end else begin
					want = results_due.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Result differs: expected %p, actual %p", want, got);
					end
				end
			end
			if (req.valid && req.ready)
				results_due.push_back(apply_request(req.cmd, req.data_word,
					req.word_offset, req.record_length, req.header_address));
			if (cfg_we)
				reserve = cfg_wdata;
			outstanding = results_due.size();
		end
	end

endmodule

### sim/testbench.sv
// Stimulus and verdict for the record ring allocator.
`timescale 1ns / 100ps
module testbench;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int SEGMENTS = 10;
	localparam int SEG_ITEMS = 170;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [12:0] cfg_wdata;
	int          mismatches;
	int          outstanding;
	int          cycles;
	int          sent;
	int          src_idle;
	int          sink_stall;
	int          reserve_now;

	vrra_in_if  req_if();
	vrra_out_if res_if();

	variable_record_ring_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (req_if),
		.out_ch   (res_if),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	ring_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.res        (res_if),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		res_if.ready <= ($urandom_range(99) >= sink_stall);
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// A request the block could only answer by reading unwritten ring words is skipped.
	task automatic send(logic [2:0] c, logic [31:0] d, logic [11:0] o, logic [11:0] l,
			logic [11:0] h);
		bit ok;
		@(negedge clk);
		chk.try_request(c, d, o, l, h, ok);
		if (!ok)
			return;
		if ($urandom_range(99) < src_idle)
			repeat ($urandom_range(1, 6)) @(posedge clk);
		@(posedge clk);
		req_if.valid <= 1;
		req_if.cmd <= c;
		req_if.data_word <= d;
		req_if.word_offset <= o;
		req_if.record_length <= l;
		req_if.header_address <= h;
		do @(posedge clk); while (!req_if.ready);
		req_if.valid <= 0;
		sent++;
	endtask

	// The count of pending results is read away from the clock edge at which it changes.
	task automatic drain();
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reserve(int v);
		drain();
		@(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= 13'(v);
		@(posedge clk);
		cfg_we <= 0;
		reserve_now = (v < 2) ? 2 : v;
		repeat (2) @(posedge clk);
	endtask

	task automatic well_formed_record();
		int maxl;
		int len;
		int nw;
		maxl = reserve_now - 3;
		if (maxl < 0) begin
			send(vrra_pkg::CMD_WRITE, $urandom, 12'd0, 12'd0, 12'd0);
			send(vrra_pkg::CMD_FLUSH, $urandom, 12'd0, 12'd0, 12'd0);
			return;
		end
		len = $urandom_range(0, (maxl < 12) ? maxl : 12);
		if ($urandom_range(9) == 0)
			len = maxl;
		nw = (len < 12) ? len : 4;
		for (int i = 0; i < nw; i++)
			send(vrra_pkg::CMD_WRITE, $urandom, 12'(i), 12'($urandom), 12'($urandom));
		send(vrra_pkg::CMD_FLUSH, $urandom, 12'($urandom), 12'(len), 12'($urandom));
		repeat ($urandom_range(0, 3))
			send(vrra_pkg::CMD_READ, $urandom, 12'($urandom_range(0, nw)), 12'($urandom),
				12'($urandom));
	endtask

	task automatic random_segment(int target);
		int pick;
		int stop_at;
		stop_at = sent + target;
		while (sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				well_formed_record();
			end else if (pick < 60) begin
				send(vrra_pkg::CMD_RELEASE, $urandom, 12'($urandom), 12'($urandom),
					chk.oldest_record());
				send(vrra_pkg::CMD_RESCAN, $urandom, 12'($urandom), 12'($urandom),
					12'($urandom));
			end else if (pick < 70) begin
				send(vrra_pkg::CMD_RESCAN, $urandom, 12'($urandom), 12'($urandom),
					12'($urandom));
			end else if (pick < 78) begin
				send(vrra_pkg::CMD_READ, $urandom, 12'($urandom_range(0, 15)),
					12'($urandom), 12'($urandom));
			end else if (pick < 83) begin
				send(vrra_pkg::CMD_WRITE, $urandom, 12'($urandom), 12'($urandom),
					12'($urandom));
			end else if (pick < 88) begin
				send(vrra_pkg::CMD_FLUSH, $urandom, 12'($urandom), 12'($urandom),
					12'($urandom));
			end else if (pick < 92) begin
				send(vrra_pkg::CMD_RELEASE, $urandom, 12'($urandom), 12'($urandom),
					12'($urandom));
			end else if (pick < 95) begin
				send(vrra_pkg::CMD_FINISH, $urandom, 12'($urandom), 12'($urandom),
					12'($urandom));
			end else if (pick < 97) begin
				send(3'($urandom_range(6, 7)), $urandom, 12'($urandom), 12'($urandom),
					12'($urandom));
			end else begin
				send(3'($urandom), $urandom, 12'($urandom), 12'($urandom), 12'($urandom));
			end
		end
	endtask

	initial begin
		int reserve_list[SEGMENTS];
		reserve_list = '{1024, 16, 2, 300, 4096, 3, 1, 2944, 64, 40};
		sent = 0;
		src_idle = 0;
		sink_stall = 0;
		reserve_now = 1024;
		arst_n <= 0;
		cfg_we <= 0;
		cfg_wdata <= '0;
		req_if.valid <= 0;
		req_if.cmd <= '0;
		req_if.data_word <= '0;
		req_if.word_offset <= '0;
		req_if.record_length <= '0;
		req_if.header_address <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed part at the reset value of the reserve.
		send(vrra_pkg::CMD_READ, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_RESCAN, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_WRITE, 32'hFFFF_FFFF, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_WRITE, 32'h0000_0000, 12'd1, 12'hFFF, 12'hFFF);
		send(vrra_pkg::CMD_WRITE, 32'hA5A5_5A5A, 12'd1021, 12'd0, 12'd0);
		send(vrra_pkg::CMD_WRITE, 32'h1234_5678, 12'd1022, 12'd0, 12'd0);
		send(vrra_pkg::CMD_WRITE, 32'h1234_5678, 12'hFFF, 12'd0, 12'd0);
		send(vrra_pkg::CMD_FLUSH, 32'd0, 12'd0, 12'd1022, 12'd0);
		send(vrra_pkg::CMD_FLUSH, 32'd0, 12'd0, 12'hFFF, 12'd0);
		send(vrra_pkg::CMD_FLUSH, 32'd0, 12'd0, 12'd2, 12'd0);
		send(vrra_pkg::CMD_READ, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_READ, 32'd0, 12'd1, 12'd0, 12'd0);
		send(vrra_pkg::CMD_READ, 32'd0, 12'd2, 12'd0, 12'd0);
		send(vrra_pkg::CMD_READ, 32'd0, 12'hFFF, 12'd0, 12'd0);
		send(vrra_pkg::CMD_FLUSH, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_RELEASE, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_RESCAN, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_FINISH, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_WRITE, 32'hDEAD_BEEF, 12'd0, 12'd0, 12'd0);
		send(3'd6, 32'hFFFF_FFFF, 12'hFFF, 12'hFFF, 12'hFFF);
		send(3'd7, 32'd0, 12'd0, 12'd0, 12'd0);
		send(vrra_pkg::CMD_READ, 32'd0, 12'd0, 12'd0, 12'd0);

		for (int s = 0; s < SEGMENTS; s++) begin
			set_reserve(reserve_list[s]);
			case (s % 4)
				0: begin src_idle = 0; sink_stall = 0; end
				1: begin src_idle = 64; sink_stall = 0; end
				2: begin src_idle = 0; sink_stall = 64; end
				default: begin src_idle = 25; sink_stall = 25; end
			endcase
			random_segment(SEG_ITEMS);
		end

		src_idle = 0;
		sink_stall = 0;
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
